// ----- design/usart_with_peripheral_dma_macros.svh -----
// Assertion macros for the UART/DMA block.
// Included by modules that carry concurrent checks.
`ifndef USART_WITH_PERIPHERAL_DMA_MACROS_SVH
`define USART_WITH_PERIPHERAL_DMA_MACROS_SVH
// implication checked every clock, reset disables
`define UD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define UD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- design/ud_pkg.sv -----
// Package for the UART/DMA block: commands, result kinds, offsets, constants.
// No dependencies.
package ud_pkg;
  typedef enum logic [1:0] {
    CMD_READ = 2'd0, CMD_WRITE = 2'd1, CMD_RXBYTE = 2'd2, CMD_TICK = 2'd3
  } cmd_t;
  typedef enum logic [2:0] {
    KIND_DONE = 3'd0, KIND_RDATA = 3'd1, KIND_TXBYTE = 3'd2,
    KIND_TXBURST = 3'd3, KIND_RXWRITE = 3'd4
  } kind_t;
  localparam logic [1:0] CFG_CHIP_ID = 2'd0;
  localparam logic [1:0] CFG_EXT_ID  = 2'd1;
  localparam logic [1:0] CFG_IDLE    = 2'd2;
  localparam logic [31:0] NAME_PLAIN = 32'h5553_4152;
  localparam logic [31:0] NAME_DEBUG = 32'h4442_4755;
  localparam logic [31:0] VER_PLAIN  = 32'h0001_0302;
  localparam logic [31:0] VER_DEBUG  = 32'h0001_0202;
  localparam logic [8:0] OFS_CR    = 9'h000;
  localparam logic [8:0] OFS_MR    = 9'h004;
  localparam logic [8:0] OFS_IER   = 9'h008;
  localparam logic [8:0] OFS_IDR   = 9'h00C;
  localparam logic [8:0] OFS_IMR   = 9'h010;
  localparam logic [8:0] OFS_CSR   = 9'h014;
  localparam logic [8:0] OFS_RHR   = 9'h018;
  localparam logic [8:0] OFS_THR   = 9'h01C;
  localparam logic [8:0] OFS_BRGR  = 9'h020;
  localparam logic [8:0] OFS_RTOR  = 9'h024;
  localparam logic [8:0] OFS_CID   = 9'h040;
  localparam logic [8:0] OFS_EXID  = 9'h044;
  localparam logic [8:0] OFS_NAME  = 9'h0F0;
  localparam logic [8:0] OFS_VER   = 9'h0FC;
  localparam logic [8:0] OFS_RPR   = 9'h100;
  localparam logic [8:0] OFS_RCR   = 9'h104;
  localparam logic [8:0] OFS_TPR   = 9'h108;
  localparam logic [8:0] OFS_TCR   = 9'h10C;
  localparam logic [8:0] OFS_RNPR  = 9'h110;
  localparam logic [8:0] OFS_RNCR  = 9'h114;
  localparam logic [8:0] OFS_TNPR  = 9'h118;
  localparam logic [8:0] OFS_TNCR  = 9'h11C;
  localparam logic [8:0] OFS_PTCR  = 9'h120;
  localparam logic [8:0] OFS_PTSR  = 9'h124;
  typedef struct packed {
    logic [1:0]  command;
    logic [8:0]  reg_offset;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;
  } in_item_t;
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] mem_address;
    logic [31:0] burst_length;
    logic [31:0] data_word;
    logic        rx_dropped;
    logic        irq_level;
    logic        last;
  } out_item_t;
  typedef struct packed {
    logic [31:0] chip_id;
    logic [31:0] ext_id;
    logic [15:0] idle_ticks;
  } cfg_regs_t;
endpackage

// ----- design/ud_if.sv -----
// Valid/ready channel interfaces for the UART/DMA block.
// Depends on ud_pkg.
interface ud_in_if;
  logic             valid;
  logic             ready;
  ud_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ud_out_if;
  logic              valid;
  logic              ready;
  ud_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ud_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/ud_front.sv -----
// Front end: takes input items and configuration writes, holds register state,
// classifies each step into up to two result items pushed to the queue.
// Depends on ud_pkg and ud_if.
module ud_front #(
  parameter int IDLE_COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  ud_in_if.sink              in_ch,
  ud_cfg_if.sink             cfg_ch,
  input  logic               q_room,
  output logic               q_push,
  output logic [1:0]         q_cnt,
  output ud_pkg::out_item_t  q_item [3]
);
  import ud_pkg::*;
  localparam logic [IDLE_COUNT_BITS-1:0] IDLE_MAX = '1;

  cfg_regs_t cfg_r;
  logic [31:0] int_mask_r, mode_r, baud_r, rto_r;
  logic timeout_r, rx_ready_r, rx_on_r, tx_on_r, rx_dma_r, tx_dma_r, idle_run_r;
  logic [7:0] rx_hold_r;
  logic [31:0] rx_ptr_r, rx_cnt_r, rx_nptr_r, rx_ncnt_r;
  logic [31:0] tx_ptr_r, tx_cnt_r, tx_nptr_r, tx_ncnt_r;
  logic [IDLE_COUNT_BITS-1:0] idle_r;

  logic [31:0] int_mask_nxt, mode_nxt, baud_nxt, rto_nxt;
  logic timeout_nxt, rx_ready_nxt, rx_on_nxt, tx_on_nxt, rx_dma_nxt, tx_dma_nxt;
  logic idle_run_nxt;
  logic [7:0] rx_hold_nxt;
  logic [31:0] rx_ptr_nxt, rx_cnt_nxt, rx_nptr_nxt, rx_ncnt_nxt;
  logic [31:0] tx_ptr_nxt, tx_cnt_nxt, tx_nptr_nxt, tx_ncnt_nxt;
  logic [IDLE_COUNT_BITS-1:0] idle_nxt;

  in_item_t it;
  out_item_t res [3];
  logic [1:0] k;
  logic [31:0] rd, st;
  logic [31:0] rdec;
  logic go, irq;
  logic [IDLE_COUNT_BITS-1:0] idle_inc;

  assign it = in_ch.payload;
  assign in_ch.ready = q_room;
  assign cfg_ch.ready = 1'b1;
  assign go = in_ch.valid && q_room;

  always_comb begin
    int_mask_nxt = int_mask_r; mode_nxt = mode_r; baud_nxt = baud_r; rto_nxt = rto_r;
    timeout_nxt = timeout_r; rx_ready_nxt = rx_ready_r; rx_on_nxt = rx_on_r;
    tx_on_nxt = tx_on_r; rx_dma_nxt = rx_dma_r; tx_dma_nxt = tx_dma_r;
    idle_run_nxt = idle_run_r; rx_hold_nxt = rx_hold_r;
    rx_ptr_nxt = rx_ptr_r; rx_cnt_nxt = rx_cnt_r; rx_nptr_nxt = rx_nptr_r;
    rx_ncnt_nxt = rx_ncnt_r; tx_ptr_nxt = tx_ptr_r; tx_cnt_nxt = tx_cnt_r;
    tx_nptr_nxt = tx_nptr_r; tx_ncnt_nxt = tx_ncnt_r; idle_nxt = idle_r;
    k = 2'd0; rd = '0; rdec = rx_cnt_r - 32'd1;
    idle_inc = idle_r;
    for (int i = 0; i < 3; i++) res[i] = '0;
    st = 32'h0000_0202;
    st[4] = (tx_cnt_r == '0);
    st[11] = (tx_cnt_r == '0) && (tx_ncnt_r == '0);
    st[3] = (rx_cnt_r == '0);
    st[12] = (rx_cnt_r == '0) && (rx_ncnt_r == '0);
    st[8] = timeout_r;
    st[0] = rx_ready_r;
    case (it.command)
      CMD_READ: begin
        case (it.reg_offset)
          OFS_MR:   rd = mode_r;
          OFS_IMR:  rd = int_mask_r;
          OFS_CSR:  rd = st;
          OFS_RHR: begin
            rd = {24'd0, rx_hold_r};
            rx_ready_nxt = 1'b0;
          end
          OFS_BRGR: rd = baud_r;
          OFS_RTOR: rd = rto_r;
          OFS_CID:  rd = cfg_r.chip_id;
          OFS_EXID: rd = (cfg_r.chip_id != '0) ? cfg_r.ext_id : '0;
          OFS_NAME: rd = (cfg_r.chip_id != '0) ? NAME_DEBUG : NAME_PLAIN;
          OFS_VER:  rd = (cfg_r.chip_id != '0) ? VER_DEBUG : VER_PLAIN;
          OFS_RPR:  rd = rx_ptr_r;
          OFS_RCR:  rd = rx_cnt_r;
          OFS_TPR:  rd = tx_ptr_r;
          OFS_TCR:  rd = tx_cnt_r;
          OFS_RNPR: rd = rx_nptr_r;
          OFS_RNCR: rd = rx_ncnt_r;
          OFS_TNPR: rd = tx_nptr_r;
          OFS_TNCR: rd = tx_ncnt_r;
          OFS_PTSR: rd = {23'd0, tx_dma_r, 7'd0, rx_dma_r};
          default:  rd = '0;
        endcase
        res[0].kind = KIND_RDATA;
        res[0].data_word = rd;
        k = 2'd1;
      end
      CMD_WRITE: begin
        case (it.reg_offset)
          OFS_CR: begin
            if (it.write_data[4]) rx_on_nxt = 1'b1;
            if (it.write_data[5]) rx_on_nxt = 1'b0;
            if (it.write_data[6]) tx_on_nxt = 1'b1;
            if (it.write_data[7]) tx_on_nxt = 1'b0;
            if (it.write_data[2]) rx_ready_nxt = 1'b0;
            if (it.write_data[11] || it.write_data[15]) begin
              timeout_nxt = 1'b0;
              idle_run_nxt = 1'b0;
              idle_nxt = '0;
            end
          end
          OFS_MR:   mode_nxt = it.write_data;
          OFS_IER:  int_mask_nxt = int_mask_r | it.write_data;
          OFS_IDR:  int_mask_nxt = int_mask_r & ~it.write_data;
          OFS_THR: begin
            res[0].kind = KIND_TXBYTE;
            res[0].data_word = {24'd0, it.write_data[7:0]};
            k = 2'd1;
          end
          OFS_BRGR: baud_nxt = it.write_data;
          OFS_RTOR: rto_nxt = it.write_data;
          OFS_RPR:  rx_ptr_nxt = it.write_data;
          OFS_RCR:  rx_cnt_nxt = it.write_data;
          OFS_TPR:  tx_ptr_nxt = it.write_data;
          OFS_TCR:  tx_cnt_nxt = it.write_data;
          OFS_RNPR: rx_nptr_nxt = it.write_data;
          OFS_RNCR: rx_ncnt_nxt = it.write_data;
          OFS_TNPR: tx_nptr_nxt = it.write_data;
          OFS_TNCR: tx_ncnt_nxt = it.write_data;
          OFS_PTCR: begin
            if (it.write_data[0]) rx_dma_nxt = 1'b1;
            if (it.write_data[1]) rx_dma_nxt = 1'b0;
            if (it.write_data[8]) tx_dma_nxt = 1'b1;
            if (it.write_data[9]) tx_dma_nxt = 1'b0;
          end
          default: ;
        endcase
        // transmit DMA: current buffer, then chained buffer (at most two)
        if ((it.reg_offset == OFS_TCR || it.reg_offset == OFS_PTCR) && tx_dma_nxt &&
            tx_cnt_nxt != '0) begin
          res[0].kind = KIND_TXBURST;
          res[0].mem_address = tx_ptr_nxt;
          res[0].burst_length = tx_cnt_nxt;
          k = 2'd1;
          tx_ptr_nxt = tx_ptr_nxt + tx_cnt_nxt;
          tx_cnt_nxt = '0;
          if (tx_ncnt_r != '0) begin
            res[1].kind = KIND_TXBURST;
            res[1].mem_address = tx_nptr_r;
            res[1].burst_length = tx_ncnt_r;
            k = 2'd2;
            tx_ptr_nxt = tx_nptr_r + tx_ncnt_r;
            tx_nptr_nxt = '0;
            tx_ncnt_nxt = '0;
          end
        end
      end
      CMD_RXBYTE: begin
        if (rx_dma_r) begin
          if (rx_cnt_r != '0) begin
            res[0].kind = KIND_RXWRITE;
            res[0].mem_address = rx_ptr_r;
            res[0].data_word = {24'd0, it.rx_byte};
            k = 2'd1;
            rx_ptr_nxt = rx_ptr_r + 32'd1;
            rx_cnt_nxt = rdec;
            if (rdec == '0 && rx_ncnt_r != '0) begin
              rx_ptr_nxt = rx_nptr_r;
              rx_cnt_nxt = rx_ncnt_r;
              rx_nptr_nxt = '0;
              rx_ncnt_nxt = '0;
            end
            idle_nxt = '0;
            idle_run_nxt = 1'b1;
          end else begin
            res[0].rx_dropped = 1'b1;
            k = 2'd1;
          end
        end else if (rx_ready_r) begin
          res[0].rx_dropped = 1'b1;
          k = 2'd1;
        end else begin
          rx_hold_nxt = it.rx_byte;
          rx_ready_nxt = 1'b1;
        end
      end
      CMD_TICK: begin
        if (idle_run_r) begin
          if (idle_r != IDLE_MAX) idle_inc = idle_r + 1'b1;
          idle_nxt = idle_inc;
          if (32'(idle_inc) >= 32'(cfg_r.idle_ticks) || idle_inc == IDLE_MAX) begin
            timeout_nxt = 1'b1;
            idle_run_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
    if (k == 2'd0) k = 2'd1;
    st = 32'h0000_0202;
    st[4] = (tx_cnt_nxt == '0);
    st[11] = (tx_cnt_nxt == '0) && (tx_ncnt_nxt == '0);
    st[3] = (rx_cnt_nxt == '0);
    st[12] = (rx_cnt_nxt == '0) && (rx_ncnt_nxt == '0);
    st[8] = timeout_nxt;
    st[0] = rx_ready_nxt;
    irq = (st & int_mask_nxt) != '0;
    for (int i = 0; i < 3; i++) begin
      res[i].irq_level = irq;
      res[i].last = (2'(i) == k - 2'd1);
    end
  end

  assign q_push = go;
  assign q_cnt = k;
  assign q_item = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{chip_id: '0, ext_id: '0, idle_ticks: 16'd2000};
      int_mask_r <= '0; mode_r <= '0; baud_r <= '0; rto_r <= '0;
      timeout_r <= 1'b0; rx_ready_r <= 1'b0; rx_on_r <= 1'b0; tx_on_r <= 1'b0;
      rx_dma_r <= 1'b0; tx_dma_r <= 1'b0; idle_run_r <= 1'b0; rx_hold_r <= '0;
      rx_ptr_r <= '0; rx_cnt_r <= '0; rx_nptr_r <= '0; rx_ncnt_r <= '0;
      tx_ptr_r <= '0; tx_cnt_r <= '0; tx_nptr_r <= '0; tx_ncnt_r <= '0;
      idle_r <= '0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_CHIP_ID: cfg_r.chip_id <= cfg_ch.data;
          CFG_EXT_ID:  cfg_r.ext_id <= cfg_ch.data;
          CFG_IDLE:    cfg_r.idle_ticks <= cfg_ch.data[15:0];
          default: ;
        endcase
      end
      if (go) begin
        int_mask_r <= int_mask_nxt; mode_r <= mode_nxt; baud_r <= baud_nxt;
        rto_r <= rto_nxt; timeout_r <= timeout_nxt; rx_ready_r <= rx_ready_nxt;
        rx_on_r <= rx_on_nxt; tx_on_r <= tx_on_nxt; rx_dma_r <= rx_dma_nxt;
        tx_dma_r <= tx_dma_nxt; idle_run_r <= idle_run_nxt; rx_hold_r <= rx_hold_nxt;
        rx_ptr_r <= rx_ptr_nxt; rx_cnt_r <= rx_cnt_nxt; rx_nptr_r <= rx_nptr_nxt;
        rx_ncnt_r <= rx_ncnt_nxt; tx_ptr_r <= tx_ptr_nxt; tx_cnt_r <= tx_cnt_nxt;
        tx_nptr_r <= tx_nptr_nxt; tx_ncnt_r <= tx_ncnt_nxt; idle_r <= idle_nxt;
      end
    end
  end
endmodule

// ----- design/ud_queue.sv -----
// Result queue: four-entry FIFO taking up to three items per push, one per pop.
// Depends on ud_pkg and ud_if; checks use the macro header.
`include "usart_with_peripheral_dma_macros.svh"
module ud_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_push,
  input  logic [1:0]         q_cnt,
  input  ud_pkg::out_item_t  q_item [3],
  output logic               q_room,
  ud_out_if.source           out_ch
);
  import ud_pkg::*;
  localparam int DEPTH = 4;
  out_item_t mem_r [DEPTH];
  logic [1:0] wp_r, rp_r;
  logic [2:0] fill_r, fill_nxt;
  logic pop;

  assign pop = out_ch.valid && out_ch.ready;
  assign q_room = (fill_r <= 3'd1);
  assign out_ch.valid = (fill_r != '0);
  assign out_ch.payload = mem_r[rp_r];

  always_comb begin
    fill_nxt = fill_r - {2'd0, pop};
    if (q_push) fill_nxt = fill_nxt + {1'b0, q_cnt};
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < q_cnt) mem_r[wp_r + 2'(i)] <= q_item[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; fill_r <= '0;
    end else begin
      if (q_push) wp_r <= wp_r + q_cnt;
      if (pop) rp_r <= rp_r + 2'd1;
      fill_r <= fill_nxt;
    end
  end

  `UD_ASSERT_IMP(a_no_overflow, clk, rst_n, 1'b1, fill_r <= 3'd4, "queue overflow")
  `UD_ASSERT_IMP(a_push_room, clk, rst_n, q_push, q_room && q_cnt != 2'd0, "push bad")
  `UD_ASSERT_NXT(a_fill_track, clk, rst_n, !q_push && !pop, $stable(fill_r), "fill drift")
endmodule

// ----- design/usart_with_peripheral_dma.sv -----
// UART register block with peripheral DMA: top level.
// Depends on ud_pkg, ud_if, ud_front and ud_queue.
//
// Channels: in_ (register read/write, received byte, tick), out_ (result
// items, one or two per input; last marks the final one), cfg_ (chip id,
// extension id and idle tick limit writes, always ready).
// The front end decodes an input and updates all register state in the
// cycle it is accepted, pushing its results into a four-entry queue.
// Results are registered in the queue and leave on out_ in order, one per cycle while out_ready is high.
// Throughput: one input per cycle when it yields one result and out_ is ready;
// an input with two results limits the next acceptance until the queue drains
// to one entry, so the sustained rate is set by the out_ side (one result/cycle).
// in_ready drops whenever the queue holds two or more results, so an out_
// stall backs up into in_ after at most two more inputs.
// Reset (rst_n low, synchronous) clears all registers, sets the idle tick
// limit to 2000 and empties the queue. No clearing pass is needed.
module usart_with_peripheral_dma #(
  parameter int IDLE_COUNT_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  ud_in_if.sink     in_ch,
  ud_out_if.source  out_ch,
  ud_cfg_if.sink    cfg_ch
);
  import ud_pkg::*;
  logic q_room, q_push;
  logic [1:0] q_cnt;
  out_item_t q_item [3];

  ud_front #(.IDLE_COUNT_BITS(IDLE_COUNT_BITS)) u_front (
    .clk, .rst_n, .in_ch, .cfg_ch, .q_room, .q_push, .q_cnt, .q_item
  );
  ud_queue u_queue (
    .clk, .rst_n, .q_push, .q_cnt, .q_item, .q_room, .out_ch
  );
endmodule
